// ===== rtl/efc_pkg.sv =====
package efc_pkg;

  // Data widths
  localparam int WORD_W  = 32;
  localparam int PROD_W  = 2 * WORD_W;
  localparam int WIDE_W  = PROD_W + 1;
  localparam int COUNT_W = 16;
  localparam int RGB_W   = 24;
  localparam int BOUND_W = 31;

  // Fixed-point scale of z and c
  localparam int FRAC_BITS = 28;

  // Palette
  localparam int PALETTE_SIZE = 16;
  localparam int PAL_IDX_W    = $clog2(PALETTE_SIZE);

  // Configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = BOUND_W;

  localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_BOUND = CFG_IDX_W'(1);

  localparam logic [COUNT_W-1:0] ITER_LIMIT_RST   = COUNT_W'(1000);
  localparam logic [BOUND_W-1:0] ESCAPE_BOUND_RST = BOUND_W'(32'h4000_0000);

  localparam logic [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  localparam logic [RGB_W-1:0] PALETTE [PALETTE_SIZE] = '{
    24'h421E0F, 24'h19071A, 24'h09012F, 24'h040449,
    24'h000764, 24'h0C2C8A, 24'h1852B1, 24'h3987D1,
    24'h86B5E5, 24'hD3ECF8, 24'hF1E9BF, 24'hF8C95F,
    24'hFFAA00, 24'hCC8000, 24'h995700, 24'h6A3403
  };

  // Channel payloads
  typedef struct packed {
    logic signed [WORD_W-1:0] c_re;
    logic signed [WORD_W-1:0] c_im;
  } point_t;

  typedef struct packed {
    logic [COUNT_W-1:0] iter_count;
    logic [RGB_W-1:0]   rgb;
  } pixel_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SUM,
    S_TEST,
    S_EMIT
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic sum;
    logic test;
    logic emit;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic limit_zero;
    logic escape;
    logic last_iter;
  } status_t;

  // Clamp a wide signed value to the signed word range
  function automatic logic [WORD_W-1:0] sat_word(input logic signed [WIDE_W-1:0] x);
    logic hi;
    logic lo;
    hi = !x[WIDE_W-1] && (|x[WIDE_W-2:WORD_W-1]);
    lo = x[WIDE_W-1] && !(&x[WIDE_W-2:WORD_W-1]);
    if (hi) begin
      return WORD_MAX;
    end else if (lo) begin
      return WORD_MIN;
    end
    return x[WORD_W-1:0];
  endfunction

  // Black for zero count or a point that reached the limit
  function automatic logic [RGB_W-1:0] pick_color(input logic [COUNT_W-1:0] n,
                                                  input logic [COUNT_W-1:0] limit);
    if (n != '0 && n < limit) begin
      return PALETTE[n[PAL_IDX_W-1:0]];
    end
    return '0;
  endfunction

endpackage

// ===== rtl/efc_point_if.sv =====
interface efc_point_if;
  logic              valid;
  logic              ready;
  efc_pkg::point_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/efc_pixel_if.sv =====
interface efc_pixel_if;
  logic              valid;
  logic              ready;
  efc_pkg::pixel_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/efc_ctrl.sv =====
module efc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  efc_pkg::status_t  status,
  output efc_pkg::cmd_t     cmd
);

  efc_pkg::state_t state, state_next;
  logic            out_full, out_full_next;

  // State and result-valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= efc_pkg::S_IDLE;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      out_full <= out_full_next;
    end
  end

  assign out_valid = out_full;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      efc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = status.limit_zero ? efc_pkg::S_EMIT : efc_pkg::S_MUL;
        end
      end
      efc_pkg::S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = efc_pkg::S_SUM;
      end
      efc_pkg::S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = efc_pkg::S_TEST;
      end
      efc_pkg::S_TEST: begin
        cmd.test   = 1'b1;
        state_next = (status.escape || status.last_iter) ? efc_pkg::S_EMIT : efc_pkg::S_MUL;
      end
      efc_pkg::S_EMIT: begin
        // wait for the result register to free up
        if (!out_full || out_ready) begin
          cmd.emit   = 1'b1;
          state_next = efc_pkg::S_IDLE;
        end
      end
      default: state_next = efc_pkg::S_IDLE;
    endcase
  end

  // Result register is full until the result is taken
  always_comb begin
    out_full_next = out_full;
    if (cmd.emit) begin
      out_full_next = 1'b1;
    end else if (out_ready) begin
      out_full_next = 1'b0;
    end
  end

endmodule

// ===== rtl/efc_datapath.sv =====
module efc_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [efc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [efc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  efc_pkg::point_t                   point,
  input  efc_pkg::cmd_t                     cmd,
  output efc_pkg::status_t                  status,
  output efc_pkg::pixel_t                   pixel
);

  localparam int W = efc_pkg::WORD_W;
  localparam int P = efc_pkg::PROD_W;
  localparam int X = efc_pkg::WIDE_W;

  logic [efc_pkg::COUNT_W-1:0] iter_limit;
  logic [efc_pkg::BOUND_W-1:0] escape_bound;

  logic signed [W-1:0] cr, ci, zr, zi, u, v;
  logic signed [P-1:0] p_rr, p_ii, p_ri;
  logic [efc_pkg::COUNT_W-1:0] n;

  logic signed [X-1:0] diff, ri_ext, u_wide, v_wide;
  logic signed [W:0]   s, zr_sum, zi_sum;
  logic [W:0]          mag;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      iter_limit   <= efc_pkg::ITER_LIMIT_RST;
      escape_bound <= efc_pkg::ESCAPE_BOUND_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        efc_pkg::CFG_ITER_LIMIT:   iter_limit   <= cfg_data[efc_pkg::COUNT_W-1:0];
        efc_pkg::CFG_ESCAPE_BOUND: escape_bound <= cfg_data[efc_pkg::BOUND_W-1:0];
        default: ;
      endcase
    end
  end

  // Scale products back: u floors by FRAC_BITS, v (doubled) by FRAC_BITS-1
  assign diff   = {p_rr[P-1], p_rr} - {p_ii[P-1], p_ii};
  assign ri_ext = {p_ri[P-1], p_ri};
  assign u_wide = diff >>> efc_pkg::FRAC_BITS;
  assign v_wide = ri_ext >>> (efc_pkg::FRAC_BITS - 1);

  // Escape test on |u+v| and next z
  assign s      = {u[W-1], u} + {v[W-1], v};
  assign mag    = s[W] ? (W+1)'(-s) : (W+1)'(s);
  assign zr_sum = {u[W-1], u} + {cr[W-1], cr};
  assign zi_sum = {v[W-1], v} + {ci[W-1], ci};

  assign status.limit_zero = (iter_limit == '0);
  assign status.escape     = (mag > {2'b00, escape_bound});
  assign status.last_iter  = ((n + 1'b1) == iter_limit);

  // Iteration registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cr <= point.c_re;
      ci <= point.c_im;
      zr <= point.c_re;
      zi <= point.c_im;
      n  <= '0;
    end
    if (cmd.mul) begin
      p_rr <= zr * zr;
      p_ii <= zi * zi;
      p_ri <= zr * zi;
    end
    if (cmd.sum) begin
      u <= efc_pkg::sat_word(u_wide);
      v <= efc_pkg::sat_word(v_wide);
    end
    if (cmd.test && !status.escape) begin
      zr <= efc_pkg::sat_word(X'(zr_sum));
      zi <= efc_pkg::sat_word(X'(zi_sum));
      n  <= n + 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pixel.iter_count <= n;
      pixel.rgb        <= efc_pkg::pick_color(n, iter_limit);
    end
  end

endmodule

// ===== rtl/escape_time_fractal_colorizer.sv =====
// Escape-time colorizer: takes one point c (signed Q4.28) per request, iterates
// z = z*z + c from z = c until |re(z*z) + im(z*z)| exceeds escape_bound or
// iteration_limit passes are done, then returns the pass count and a 24-bit color
// (black for a count of zero or at the limit, else palette entry count mod 16).
// Each pass steps through the shared multiply / scale / test datapath in turn,
// between accepting the point and writing the result; the default limit is 1000.
// One point is in flight at a time; the next is accepted while the prior
// result still waits in the output register. Configuration writes take effect
// at once, so make them only while no point is in flight.
module escape_time_fractal_colorizer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [efc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [efc_pkg::CFG_DATA_W-1:0]  cfg_data,
  efc_point_if.sink                       point,
  efc_pixel_if.source                     pixel
);

  efc_pkg::cmd_t    cmd;
  efc_pkg::status_t status;

  efc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (point.valid),
    .in_ready  (point.ready),
    .out_valid (pixel.valid),
    .out_ready (pixel.ready),
    .status    (status),
    .cmd       (cmd)
  );

  efc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .point     (point.data),
    .cmd       (cmd),
    .status    (status),
    .pixel     (pixel.data)
  );

endmodule
